// ===== design/scme_pkg.sv =====
package scme_pkg;

  localparam int CoordW = 32;
  localparam int ValW   = 32;
  localparam int EntryW = CoordW + ValW;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ORDER    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // merge modes; every other code selects the intersection product
  localparam logic [1:0] MODE_SUM  = 2'd0;
  localparam logic [1:0] MODE_DIFF = 2'd1;

  // register index carried in paddr[2]
  localparam logic REG_MODE = 1'b0;

  typedef struct packed {
    logic load;    // input transfer accepted
    logic step;    // compare heads, advance pointers
    logic commit;  // finish value, move it into the pending slot
    logic flush;   // emit the final result, clear job state
  } cmd_t;

  typedef struct packed {
    logic done;      // both pointers past their counts
    logic err;       // an error is recorded for this job
    logic calc_ok;   // commit can proceed this cycle
    logic out_free;  // output register can take a result
  } stat_t;

endpackage

// ===== design/scme_ram.sv =====
module scme_ram #(
  parameter int DataWidth = 64,
  parameter int Depth     = 32
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [DataWidth-1:0]                 wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [DataWidth-1:0]                 rdata_o
);

  logic [DataWidth-1:0] mem [Depth];
  logic [DataWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/scme_ctrl.sv =====
module scme_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  input  scme_pkg::stat_t stat_i,
  output scme_pkg::cmd_t  cmd_o
);
  import scme_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_CMP   = 5'b00100,
    S_CALC  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.load   = accept;
    case (state_q)
      S_IDLE: begin
        if (accept && in_last_i) state_d = S_START;
      end
      // RAM heads are being read this cycle
      S_START: begin
        if (stat_i.err || stat_i.done) state_d = S_FLUSH;
        else state_d = S_CMP;
      end
      S_CMP: begin
        cmd_o.step = 1'b1;
        state_d    = S_CALC;
      end
      S_CALC: begin
        if (stat_i.calc_ok) begin
          cmd_o.commit = 1'b1;
          state_d      = stat_i.done ? S_FLUSH : S_CMP;
        end
      end
      S_FLUSH: begin
        if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/scme_dp.sv =====
module scme_dp #(
  parameter int MAX_NNZ = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  scme_pkg::cmd_t            cmd_i,
  output scme_pkg::stat_t           stat_o,
  input  logic [1:0]                mode_i,
  input  logic                      operand_i,
  input  logic                      has_entry_i,
  input  logic [15:0]               row_i,
  input  logic [15:0]               col_i,
  input  logic signed [31:0]        value_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [15:0]               row_res_o,
  output logic [15:0]               col_res_o,
  output logic signed [31:0]        value_res_o,
  output logic                      entry_valid_o,
  output scme_pkg::status_e         status_o,
  output logic                      last_o
);
  import scme_pkg::*;

  localparam int CW = $clog2(MAX_NNZ + 1);
  localparam int AW = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else r = v[31:0];
    return r;
  endfunction

  // round half up, floor shift, saturate
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic signed [63:0] s;
    logic signed [63:0] r;
    logic signed [31:0] o;
    s = p + 64'sd32768;
    r = s >>> 16;
    if (r[63:31] == '0 || r[63:31] == '1) o = r[31:0];
    else o = r[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return o;
  endfunction

  logic [CW-1:0]     lcnt_q, lcnt_d, rcnt_q, rcnt_d;
  logic [CoordW-1:0] llast_q, llast_d, rlast_q, rlast_d;
  status_e           err_q, err_d;
  logic [CW-1:0]     i_q, i_d, j_q, j_d;

  logic              emit_q, emit_d;
  logic              both_q, both_d;
  logic [CoordW-1:0] coord_q, coord_d;
  logic signed [32:0] sum_q, sum_d;
  logic signed [63:0] prod_q;

  logic              pend_valid_q, pend_valid_d;
  logic [CoordW-1:0] pend_coord_q;
  logic signed [31:0] pend_val_q;

  logic              out_valid_q, out_valid_d;
  logic [CoordW-1:0] out_coord_q;
  logic signed [31:0] out_val_q;
  logic              out_entry_q;
  status_e           out_status_q;
  logic              out_last_q;

  logic [CoordW-1:0] in_coord;
  logic              inter, sub;
  logic              l_we, r_we;
  logic [EntryW-1:0] l_rd, r_rd;
  logic [CoordW-1:0] lc, rc;
  logic signed [31:0] a, b;
  logic              il, jr;
  logic signed [31:0] new_val;
  logic              out_free;
  logic              push_pend;

  assign in_coord = {row_i, col_i};
  assign inter    = (mode_i != MODE_SUM) && (mode_i != MODE_DIFF);
  assign sub      = (mode_i == MODE_DIFF);
  assign out_free = !out_valid_q || out_ready_i;

  // ---------------- load and error checks ----------------
  always_comb begin
    lcnt_d  = lcnt_q;
    rcnt_d  = rcnt_q;
    llast_d = llast_q;
    rlast_d = rlast_q;
    err_d   = err_q;
    l_we    = 1'b0;
    r_we    = 1'b0;
    if (cmd_i.load && has_entry_i) begin
      if (!operand_i) begin
        if (lcnt_q != '0 && in_coord <= llast_q) begin
          if (err_q == ST_OK) err_d = ST_ORDER;
        end else if (lcnt_q >= CW'(MAX_NNZ)) begin
          if (err_q == ST_OK) err_d = ST_OVERFLOW;
        end else begin
          l_we    = 1'b1;
          lcnt_d  = lcnt_q + CW'(1);
          llast_d = in_coord;
        end
      end else begin
        if (rcnt_q != '0 && in_coord <= rlast_q) begin
          if (err_q == ST_OK) err_d = ST_ORDER;
        end else if (rcnt_q >= CW'(MAX_NNZ)) begin
          if (err_q == ST_OK) err_d = ST_OVERFLOW;
        end else begin
          r_we    = 1'b1;
          rcnt_d  = rcnt_q + CW'(1);
          rlast_d = in_coord;
        end
      end
    end
    if (cmd_i.flush) begin
      lcnt_d  = '0;
      rcnt_d  = '0;
      llast_d = '0;
      rlast_d = '0;
      err_d   = ST_OK;
    end
  end

  scme_ram #(.DataWidth(EntryW), .Depth(MAX_NNZ)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (lcnt_q[AW-1:0]),
    .wdata_i ({in_coord, value_i}),
    .raddr_i (i_q[AW-1:0]),
    .rdata_o (l_rd)
  );

  scme_ram #(.DataWidth(EntryW), .Depth(MAX_NNZ)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (rcnt_q[AW-1:0]),
    .wdata_i ({in_coord, value_i}),
    .raddr_i (j_q[AW-1:0]),
    .rdata_o (r_rd)
  );

  // ---------------- merge compare step ----------------
  assign lc = l_rd[EntryW-1:ValW];
  assign rc = r_rd[EntryW-1:ValW];
  assign a  = l_rd[ValW-1:0];
  assign b  = r_rd[ValW-1:0];
  assign il = (i_q < lcnt_q);
  assign jr = (j_q < rcnt_q);

  always_comb begin
    i_d     = i_q;
    j_d     = j_q;
    emit_d  = emit_q;
    both_d  = both_q;
    coord_d = coord_q;
    sum_d   = sum_q;
    if (cmd_i.step) begin
      if (!jr || (il && lc < rc)) begin
        i_d     = i_q + CW'(1);
        emit_d  = !inter;
        both_d  = 1'b0;
        coord_d = lc;
        sum_d   = 33'(a);
      end else if (!il || rc < lc) begin
        j_d     = j_q + CW'(1);
        emit_d  = !inter;
        both_d  = 1'b0;
        coord_d = rc;
        sum_d   = sub ? -33'(b) : 33'(b);
      end else begin
        i_d     = i_q + CW'(1);
        j_d     = j_q + CW'(1);
        emit_d  = 1'b1;
        both_d  = 1'b1;
        coord_d = lc;
        sum_d   = sub ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
      end
    end
    if (cmd_i.flush) begin
      i_d = '0;
      j_d = '0;
    end
  end

  // ---------------- finish value, pending slot, output ----------------
  assign new_val = (inter && both_q) ? qround(prod_q) : sat33(sum_q);

  // an emitted value waits in the pending slot until we know if it is the last
  assign stat_o.calc_ok  = !(emit_q && pend_valid_q && !out_free);
  assign stat_o.done     = (i_q >= lcnt_q) && (j_q >= rcnt_q);
  assign stat_o.err      = (err_q != ST_OK);
  assign stat_o.out_free = out_free;

  assign push_pend = cmd_i.commit && emit_q && pend_valid_q;

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (cmd_i.commit && emit_q) pend_valid_d = 1'b1;
    if (cmd_i.flush) pend_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (push_pend || cmd_i.flush) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcnt_q       <= '0;
      rcnt_q       <= '0;
      llast_q      <= '0;
      rlast_q      <= '0;
      err_q        <= ST_OK;
      i_q          <= '0;
      j_q          <= '0;
      emit_q       <= 1'b0;
      both_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      lcnt_q       <= lcnt_d;
      rcnt_q       <= rcnt_d;
      llast_q      <= llast_d;
      rlast_q      <= rlast_d;
      err_q        <= err_d;
      i_q          <= i_d;
      j_q          <= j_d;
      emit_q       <= emit_d;
      both_q       <= both_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    coord_q <= coord_d;
    sum_q   <= sum_d;
    if (cmd_i.step) prod_q <= 64'(a) * 64'(b);
    if (cmd_i.commit && emit_q) begin
      pend_coord_q <= coord_q;
      pend_val_q   <= new_val;
    end
    if (push_pend) begin
      out_coord_q  <= pend_coord_q;
      out_val_q    <= pend_val_q;
      out_entry_q  <= 1'b1;
      out_status_q <= ST_OK;
      out_last_q   <= 1'b0;
    end else if (cmd_i.flush) begin
      out_last_q <= 1'b1;
      if (pend_valid_q) begin
        out_coord_q  <= pend_coord_q;
        out_val_q    <= pend_val_q;
        out_entry_q  <= 1'b1;
        out_status_q <= ST_OK;
      end else begin
        // error or empty merge: one entry-less result
        out_coord_q  <= '0;
        out_val_q    <= '0;
        out_entry_q  <= 1'b0;
        out_status_q <= err_q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign row_res_o     = out_coord_q[CoordW-1:16];
  assign col_res_o     = out_coord_q[15:0];
  assign value_res_o   = out_val_q;
  assign entry_valid_o = out_entry_q;
  assign status_o      = out_status_q;
  assign last_o        = out_last_q;

endmodule

// ===== design/sparse_coo_merge_engine.sv =====
// Channel   | Dir | Handshake                     | Payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready | entry, operand/has_entry, last_of_job
// m_axis    | out | m_axis_tvalid / m_axis_tready | result entry, entry_valid/status, last
// apb       | in  | psel, penable, pwrite, pready | mode register at address 0
//
// Loading takes one cycle per input transfer. On the last item the merge runs:
// the store heads are read, then each merge step compares and multiplies
// against the registered RAM read, then rounds/saturates; then the final
// result is emitted. Store reads are one port per store, registered.
// The merge stalls while the output register is full; input is not taken
// during a merge. Reset clears counts and control; the stores are not cleared.
module sparse_coo_merge_engine #(
  parameter int MAX_NNZ = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // row[15:0], col[31:16], value[63:32]
  input  logic [1:0]  s_axis_tuser,   // operand[0], has_entry[1]
  input  logic        s_axis_tlast,   // last_of_job
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // row_res[15:0], col_res[31:16], value_res[63:32]
  output logic [2:0]  m_axis_tuser,   // entry_valid[0], status[2:1]
  output logic        m_axis_tlast,   // last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import scme_pkg::*;

  logic [1:0] mode_q;
  cmd_t       cmd;
  stat_t      stat;
  logic [15:0] row_res, col_res;
  logic signed [31:0] value_res;
  logic        entry_valid;
  status_e     status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE) ? {30'b0, mode_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SUM;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MODE) begin
      mode_q <= pwdata[1:0];
    end
  end

  scme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  scme_dp #(.MAX_NNZ(MAX_NNZ)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .mode_i        (mode_q),
    .operand_i     (s_axis_tuser[0]),
    .has_entry_i   (s_axis_tuser[1]),
    .row_i         (s_axis_tdata[15:0]),
    .col_i         (s_axis_tdata[31:16]),
    .value_i       (s_axis_tdata[63:32]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .row_res_o     (row_res),
    .col_res_o     (col_res),
    .value_res_o   (value_res),
    .entry_valid_o (entry_valid),
    .status_o      (status),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {value_res, col_res, row_res};
  assign m_axis_tuser = {status, entry_valid};

endmodule
